>>> sv/interval_timer_three_channel_macros.svh
// Assertion shorthands for the interval timer. They expect clk and arst_n in scope.
`ifndef INTERVAL_TIMER_THREE_CHANNEL_MACROS_SVH
`define INTERVAL_TIMER_THREE_CHANNEL_MACROS_SVH

// The consequence must hold in the cycle after the antecedent.
`define ITT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("interval timer check failed");

// The consequence must hold in the same cycle as the antecedent.
`define ITT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("interval timer check failed");

`endif

>>> sv/itt_pkg.sv
package itt_pkg;

	// Item kinds.
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_ACK   = 2'd3;

	localparam logic [1:0] PORT_CONTROL = 2'd3;

	// Access field of the control word.
	localparam logic [1:0] ACC_LATCH = 2'd0;
	localparam logic [1:0] ACC_LOW   = 2'd1;
	localparam logic [1:0] ACC_HIGH  = 2'd2;
	localparam logic [1:0] ACC_BOTH  = 2'd3;

	// Counter modes that matter here.
	localparam logic [2:0] MODE_TERMINAL = 3'd0;
	localparam logic [2:0] MODE_RATE     = 3'd2;
	localparam logic [2:0] MODE_SQUARE   = 3'd3;

	localparam int CH0_W = 18;
	localparam int CH2_W = 32;
	localparam int ALU_W = 33;

	localparam logic [16:0] FULL_PERIOD      = 17'h10000;
	localparam logic [15:0] ULTRASONIC_LIMIT = 16'd80;
	localparam logic [15:0] RELOAD_DEFAULT   = 16'd1024;
	localparam logic [7:0]  IRQ_MAX          = 8'hFF;
	localparam logic [7:0]  CONTROL_DEFAULT  = 8'hFF;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] port_offset;
		logic [7:0] write_data;
		logic [7:0] tick_count;
	} itt_cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       timer2_level;
		logic       timer2_ultrasonic;
		logic [7:0] irq0_waiting;
		logic       irq0_granted;
	} itt_res_t;

endpackage

>>> sv/interval_timer_three_channel.sv
// Three-channel interval timer. Each transfer on cmd is one item (tick batch, port write,
// port read or interrupt acknowledge) and yields exactly one transfer on res. Port writes,
// reads and acknowledges pass through the EXEC and DONE states to the result register. A
// tick batch steps through T0SUB, T0LOOP once per channel 0 reload and once more to leave
// it, T2SUB, T2FIX and, in channel 2 mode 3, T2CMP, then DONE. All counter arithmetic runs
// through one shared 33-bit adder stepped by a small sequencer. A new item is taken once
// the previous result has moved into the output register, even while that result still
// waits to be taken.
module interval_timer_three_channel
	import itt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  itt_cmd_t cmd,
	output logic     res_valid,
	input  logic     res_stall,
	output itt_res_t res
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_EXEC   = 8'b0000_0010,
		S_T0SUB  = 8'b0000_0100,
		S_T0LOOP = 8'b0000_1000,
		S_T2SUB  = 8'b0001_0000,
		S_T2FIX  = 8'b0010_0000,
		S_T2CMP  = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} itt_state_t;

	itt_state_t state_q;
	itt_cmd_t   cmd_q;

	logic [2:0]  mode_q    [3];
	logic [1:0]  access_q  [3];
	logic [15:0] holding_q [3];
	logic [15:0] reload_q  [3];
	logic [15:0] snap_q    [3];
	logic [2:0]  snap_valid_q;
	logic [2:0]  low_next_q;

	logic signed [CH0_W-1:0] c0_q;
	logic [15:0]             c1_q;
	logic [CH2_W-1:0]        c2_q;

	logic       timer2_q;
	logic       ultra_q;
	logic [7:0] irq_q;
	logic [7:0] control_q;
	logic [7:0] rd_q;
	logic       granted_q;

	itt_res_t res_q;
	logic     res_valid_q;

	logic             cmd_take;
	logic             res_free;
	logic [1:0]       sel_ch;
	logic [15:0]      cnt16;
	logic [15:0]      word;
	logic             lo_now;
	logic [15:0]      new_holding;
	logic [16:0]      period0;
	logic [16:0]      period2;
	logic             c0_le0;
	logic             c2_le0;
	logic [31:0]      alu_a;
	logic [31:0]      alu_b;
	logic             alu_sub;
	logic [ALU_W-1:0] alu_sum;

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign res_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A control word with select 3 acts on channel 2.
	always_comb begin
		if (cmd_q.port_offset != PORT_CONTROL) begin
			sel_ch = cmd_q.port_offset;
		end else if (cmd_q.write_data[7:6] == 2'd3) begin
			sel_ch = 2'd2;
		end else begin
			sel_ch = cmd_q.write_data[7:6];
		end
	end

	always_comb begin
		case (sel_ch)
			2'd0:    cnt16 = c0_q[15:0];
			2'd1:    cnt16 = c1_q;
			default: cnt16 = c2_q[15:0];
		endcase
	end

	assign word   = snap_valid_q[sel_ch] ? snap_q[sel_ch] : cnt16;
	assign lo_now = (access_q[sel_ch] == ACC_LOW) ||
		((access_q[sel_ch] == ACC_BOTH) && low_next_q[sel_ch]);
	assign new_holding = lo_now ? {holding_q[sel_ch][15:8], cmd_q.write_data}
		: {cmd_q.write_data, holding_q[sel_ch][7:0]};

	assign period0 = (reload_q[0] == 16'd0) ? FULL_PERIOD : {1'b0, reload_q[0]};
	assign period2 = (reload_q[2] == 16'd0) ? FULL_PERIOD : {1'b0, reload_q[2]};
	assign c0_le0  = c0_q[CH0_W-1] || (c0_q == '0);
	assign c2_le0  = c2_q[CH2_W-1] || (c2_q == '0);

	// Shared adder: signed a plus or minus a non-negative b.
	always_comb begin
		alu_a   = 32'd0;
		alu_b   = 32'd0;
		alu_sub = 1'b0;
		case (state_q)
			S_T0SUB: begin
				alu_a   = 32'(c0_q);
				alu_b   = {24'd0, cmd_q.tick_count};
				alu_sub = 1'b1;
			end
			S_T0LOOP: begin
				alu_a = 32'(c0_q);
				alu_b = {15'd0, period0};
			end
			S_T2SUB: begin
				alu_a   = c2_q;
				alu_b   = {24'd0, cmd_q.tick_count};
				alu_sub = 1'b1;
			end
			S_T2FIX: begin
				alu_a = c2_q;
				alu_b = {15'd0, period2};
			end
			S_T2CMP: begin
				alu_a   = c2_q;
				alu_b   = {17'd0, reload_q[2][15:1]};
				alu_sub = 1'b1;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_sum = {alu_a[31], alu_a} + ({alu_b[31], alu_b} ^ {ALU_W{alu_sub}})
		+ ALU_W'(alu_sub);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			mode_q       <= '{MODE_RATE, MODE_RATE, MODE_SQUARE};
			access_q     <= '{ACC_BOTH, ACC_BOTH, ACC_BOTH};
			holding_q    <= '{16'd0, RELOAD_DEFAULT, RELOAD_DEFAULT};
			reload_q     <= '{16'd0, RELOAD_DEFAULT, RELOAD_DEFAULT};
			snap_q       <= '{16'd0, 16'd0, 16'd0};
			snap_valid_q <= 3'b000;
			low_next_q   <= 3'b111;
			c0_q         <= '0;
			c1_q         <= RELOAD_DEFAULT;
			c2_q         <= {16'd0, RELOAD_DEFAULT};
			timer2_q     <= 1'b0;
			ultra_q      <= 1'b0;
			irq_q        <= 8'd0;
			control_q    <= CONTROL_DEFAULT;
			rd_q         <= 8'd0;
			granted_q    <= 1'b0;
			res_q        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						cmd_q     <= cmd;
						rd_q      <= 8'd0;
						granted_q <= 1'b0;
						state_q   <= (cmd.kind == KIND_TICK) ? S_T0SUB : S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (cmd_q.kind)
						KIND_WRITE: begin
							if (cmd_q.port_offset == PORT_CONTROL) begin
								control_q <= cmd_q.write_data;
								mode_q[sel_ch] <= cmd_q.write_data[3:1];
								if (cmd_q.write_data[5:4] == ACC_LATCH) begin
									snap_q[sel_ch]       <= cnt16;
									snap_valid_q[sel_ch] <= 1'b1;
									low_next_q[sel_ch]   <= 1'b1;
								end else begin
									access_q[sel_ch] <= cmd_q.write_data[5:4];
									if (cmd_q.write_data[5:4] == ACC_BOTH) begin
										low_next_q[sel_ch] <= 1'b1;
									end
								end
							end else begin
								if (access_q[sel_ch] == ACC_BOTH) begin
									low_next_q[sel_ch] <= !low_next_q[sel_ch];
								end
								holding_q[sel_ch] <= new_holding;
								// The high byte completes the word and commits it.
								if (!lo_now) begin
									reload_q[sel_ch] <= new_holding;
									if (mode_q[sel_ch] == MODE_TERMINAL) begin
										case (sel_ch)
											2'd0:    c0_q <= CH0_W'(new_holding);
											2'd1:    c1_q <= new_holding;
											default: c2_q <= CH2_W'(new_holding);
										endcase
									end
									if (sel_ch == 2'd2) begin
										ultra_q <= (new_holding < ULTRASONIC_LIMIT);
									end
								end
							end
						end
						KIND_READ: begin
							if (cmd_q.port_offset == PORT_CONTROL) begin
								rd_q <= control_q;
							end else begin
								rd_q <= lo_now ? word[7:0] : word[15:8];
								if (access_q[sel_ch] == ACC_BOTH) begin
									low_next_q[sel_ch] <= !low_next_q[sel_ch];
								end
								// Reading the last byte of the word releases the latch.
								if (!lo_now || (access_q[sel_ch] == ACC_LOW)) begin
									snap_valid_q[sel_ch] <= 1'b0;
								end
							end
						end
						KIND_ACK: begin
							if (irq_q != 8'd0) begin
								irq_q     <= irq_q - 8'd1;
								granted_q <= 1'b1;
							end
						end
						default: begin
							granted_q <= 1'b0;
						end
					endcase
				end
				S_T0SUB: begin
					c0_q    <= alu_sum[CH0_W-1:0];
					state_q <= S_T0LOOP;
				end
				S_T0LOOP: begin
					if (c0_le0) begin
						c0_q <= alu_sum[CH0_W-1:0];
						if (irq_q != IRQ_MAX) begin
							irq_q <= irq_q + 8'd1;
						end
					end else begin
						state_q <= S_T2SUB;
					end
				end
				S_T2SUB: begin
					c2_q    <= alu_sum[CH2_W-1:0];
					state_q <= S_T2FIX;
				end
				S_T2FIX: begin
					if (mode_q[2] == MODE_RATE) begin
						timer2_q <= c2_le0;
						if (c2_le0) begin
							c2_q <= alu_sum[CH2_W-1:0];
						end
						state_q <= S_DONE;
					end else if (mode_q[2] == MODE_SQUARE) begin
						if (c2_le0) begin
							c2_q <= alu_sum[CH2_W-1:0];
						end
						state_q <= S_T2CMP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_T2CMP: begin
					// High while the count is at least half the reload.
					timer2_q <= !alu_sum[ALU_W-1];
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (res_free) begin
						res_q.read_data         <= rd_q;
						res_q.timer2_level      <= timer2_q;
						res_q.timer2_ultrasonic <= ultra_q;
						res_q.irq0_waiting      <= irq_q;
						res_q.irq0_granted      <= granted_q;
						state_q                 <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/itt_checker.sv
`include "interval_timer_three_channel_macros.svh"

module itt_checker
	import itt_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     cmd_valid,
	input logic     cmd_stall,
	input logic     res_valid,
	input logic     res_stall,
	input itt_res_t res
);

	// Every item keeps the block busy in the cycle after its transfer.
	`ITT_ASSERT_NEXT(a_busy_after_transfer, cmd_valid && !cmd_stall, cmd_stall)

	`ITT_ASSERT_NEXT(a_res_held, res_valid && res_stall, res_valid && $stable(res))

	// A new result only appears when work on an item has just finished.
	`ITT_ASSERT_SAME(a_res_after_work, $rose(res_valid), $past(cmd_stall))

endmodule

bind interval_timer_three_channel itt_checker u_itt_checker (.*);

>>> tb/timer_result_checker.sv
module timer_result_checker
	import itt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  logic     cmd_stall,
	input  itt_cmd_t cmd,
	input  logic     res_valid,
	input  logic     res_stall,
	input  itt_res_t res,
	output int       mismatches,
	output int       due_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [2:0]  mode_r [3];
	logic [1:0]  access_r [3];
	logic        bcd_r [3];
	logic [15:0] hold_word [3];
	logic [15:0] reload_word [3];
	logic [31:0] count_word [3];
	logic [15:0] latch_word [3];
	logic        latched [3];
	logic        low_due [3];
	logic        t2_level;
	logic        t2_ultra;
	logic [7:0]  irq_waiting;
	logic [7:0]  control_byte;

	itt_res_t due_results [$];

	task automatic reset_timer_model();
		for (int i = 0; i < 3; i++) begin
			access_r[i] = ACC_BOTH;
			bcd_r[i] = 1'b0;
			latch_word[i] = '0;
			latched[i] = 1'b0;
			low_due[i] = 1'b1;
		end
		mode_r[0] = MODE_RATE;
		mode_r[1] = MODE_RATE;
		mode_r[2] = MODE_SQUARE;
		hold_word[0] = '0;
		reload_word[0] = '0;
		count_word[0] = '0;
		for (int i = 1; i < 3; i++) begin
			hold_word[i] = RELOAD_DEFAULT;
			reload_word[i] = RELOAD_DEFAULT;
			count_word[i] = 32'(RELOAD_DEFAULT);
		end
		t2_level = 1'b0;
		t2_ultra = 1'b0;
		irq_waiting = '0;
		control_byte = CONTROL_DEFAULT;
	endtask

	// A reload word of zero stands for the full 16-bit period.
	function automatic logic [31:0] period_of(int ch);
		return (reload_word[ch] == 16'd0) ? 32'(FULL_PERIOD) : 32'(reload_word[ch]);
	endfunction

	// Picks the byte lane of a data port access and, in the two-byte access mode, advances the byte toggle.
	function automatic logic take_low_byte(int ch);
		logic lo;
		if (access_r[ch] == ACC_LOW) begin
			return 1'b1;
		end
		if (access_r[ch] == ACC_BOTH) begin
			lo = low_due[ch];
			low_due[ch] = !lo;
			return lo;
		end
		return 1'b0;
	endfunction

	function automatic itt_res_t timer_step(itt_cmd_t item);
		itt_res_t r;
		int ch;
		logic [15:0] word;
		logic [1:0] acc_field;
		r = '0;
		case (item.kind)
		KIND_TICK: begin
			count_word[0] = count_word[0] - 32'(item.tick_count);
			while ($signed(count_word[0]) <= 0) begin
				count_word[0] = count_word[0] + period_of(0);
				if (irq_waiting != IRQ_MAX) begin
					irq_waiting = irq_waiting + 8'd1;
				end
			end
			count_word[2] = count_word[2] - 32'(item.tick_count);
			if (mode_r[2] == MODE_RATE) begin
				t2_level = 1'b0;
				if ($signed(count_word[2]) <= 0) begin
					count_word[2] = count_word[2] + period_of(2);
					t2_level = 1'b1;
				end
			end else if (mode_r[2] == MODE_SQUARE) begin
				if ($signed(count_word[2]) <= 0) begin
					count_word[2] = count_word[2] + period_of(2);
				end
				t2_level = ($signed(count_word[2]) >= $signed({17'd0, reload_word[2][15:1]}));
			end
		end
		KIND_WRITE: begin
			if (item.port_offset == PORT_CONTROL) begin
				ch = (item.write_data[7:6] == 2'd3) ? 2 : int'(item.write_data[7:6]);
				acc_field = item.write_data[5:4];
				control_byte = item.write_data;
				if (acc_field == ACC_LATCH) begin
					latch_word[ch] = count_word[ch][15:0];
					latched[ch] = 1'b1;
					low_due[ch] = 1'b1;
				end else begin
					access_r[ch] = acc_field;
					if (acc_field == ACC_BOTH) begin
						low_due[ch] = 1'b1;
					end
				end
				mode_r[ch] = item.write_data[3:1];
				bcd_r[ch] = item.write_data[0];
			end else begin
				ch = int'(item.port_offset);
				if (take_low_byte(ch)) begin
					hold_word[ch] = {hold_word[ch][15:8], item.write_data};
				end else begin
					hold_word[ch] = {item.write_data, hold_word[ch][7:0]};
					reload_word[ch] = hold_word[ch];
					if (mode_r[ch] == MODE_TERMINAL) begin
						count_word[ch] = 32'(reload_word[ch]);
					end
					if (ch == 2) begin
						t2_ultra = (reload_word[2] < ULTRASONIC_LIMIT);
					end
				end
			end
		end
		KIND_READ: begin
			if (item.port_offset == PORT_CONTROL) begin
				r.read_data = control_byte;
			end else begin
				ch = int'(item.port_offset);
				word = latched[ch] ? latch_word[ch] : count_word[ch][15:0];
				if (take_low_byte(ch)) begin
					r.read_data = word[7:0];
					if (access_r[ch] == ACC_LOW) begin
						latched[ch] = 1'b0;
					end
				end else begin
					r.read_data = word[15:8];
					latched[ch] = 1'b0;
				end
			end
		end
		KIND_ACK: begin
			if (irq_waiting != 8'd0) begin
				irq_waiting = irq_waiting - 8'd1;
				r.irq0_granted = 1'b1;
			end
		end
		default: begin
		end
		endcase
		r.timer2_level = t2_level;
		r.timer2_ultrasonic = t2_ultra;
		r.irq0_waiting = irq_waiting;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t: %s got 0x%02h, expected 0x%02h", $time, what, got, want);
		mismatches++;
	endtask

	initial begin
		mismatches = 0;
		due_count = 0;
		reset_timer_model();
	end

	always @(posedge clk or negedge arst_n) begin
		itt_res_t want;
		if (!arst_n) begin
			reset_timer_model();
			due_results.delete();
		end else begin
			if (res_valid && !res_stall) begin
				if (due_results.size() == 0) begin
					report_mismatch("result transfer with nothing due, read_data",
						res.read_data, 8'h00);
				end else begin
					want = due_results.pop_front();
					if (res.read_data !== want.read_data)
						report_mismatch("read_data", res.read_data, want.read_data);
					if (res.timer2_level !== want.timer2_level)
						report_mismatch("timer2_level", 8'(res.timer2_level),
							8'(want.timer2_level));
					if (res.timer2_ultrasonic !== want.timer2_ultrasonic)
						report_mismatch("timer2_ultrasonic", 8'(res.timer2_ultrasonic),
							8'(want.timer2_ultrasonic));
					if (res.irq0_waiting !== want.irq0_waiting)
						report_mismatch("irq0_waiting", res.irq0_waiting,
							want.irq0_waiting);
					if (res.irq0_granted !== want.irq0_granted)
						report_mismatch("irq0_granted", 8'(res.irq0_granted),
							8'(want.irq0_granted));
				end
			end
			if (cmd_valid && !cmd_stall) begin
				due_results.push_back(timer_step(cmd));
			end
		end
		due_count = due_results.size();
	end

endmodule

>>> tb/tb_interval_timer_three_channel.sv
module tb_interval_timer_three_channel;
	timeunit 1ns;
	timeprecision 1ps;
	import itt_pkg::*;

	localparam int ITEM_TARGET  = 1750;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_CYCLES  = 400;

	logic     clk;
	logic     arst_n = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_stall;
	itt_cmd_t cmd = '0;
	logic     res_valid;
	logic     res_stall = 1'b0;
	itt_res_t res;

	int   mismatches;
	int   due_count;
	int   items_sent = 0;
	int   cycle_count = 0;
	logic hold_done = 1'b0;

	interval_timer_three_channel DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	timer_result_checker check_u (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.mismatches (mismatches),
		.due_count  (due_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic itt_cmd_t make_item(logic [1:0] kind, logic [1:0] port,
			logic [7:0] data, logic [7:0] ticks);
		itt_cmd_t item;
		item.kind = kind;
		item.port_offset = port;
		item.write_data = data;
		item.tick_count = ticks;
		return item;
	endfunction

	function automatic logic [7:0] control_word(logic [1:0] sel, logic [1:0] acc,
			logic [2:0] mode, logic bcd);
		return {sel, acc, mode, bcd};
	endfunction

	// Holds the payload steady until the transfer happens. Stretches of idle
	// cycles are skipped in one window of the run.
	task automatic offer(input itt_cmd_t item);
		while (!(items_sent >= 600 && items_sent < 800) && $urandom_range(0, 99) < 19) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= item;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic write_port(input logic [1:0] port, input logic [7:0] data);
		offer(make_item(KIND_WRITE, port, data, 8'($urandom)));
	endtask

	task automatic read_port(input logic [1:0] port);
		offer(make_item(KIND_READ, port, 8'($urandom), 8'($urandom)));
	endtask

	task automatic run_ticks(input logic [7:0] ticks);
		offer(make_item(KIND_TICK, 2'($urandom), 8'($urandom), ticks));
	endtask

	task automatic acknowledge();
		offer(make_item(KIND_ACK, 2'($urandom), 8'($urandom), 8'($urandom)));
	endtask

	// Result side: random stalls, one window with none, and one long hold-off
	// while the sender keeps offering so the block backs up.
	initial begin
		forever begin
			if (!hold_done && items_sent >= 400) begin
				for (int n = 0; n < HOLD_CYCLES; n++) begin
					res_stall <= 1'b1;
					@(posedge clk);
				end
				hold_done = 1'b1;
			end else begin
				res_stall <= !(items_sent >= 1000 && items_sent < 1200)
					&& ($urandom_range(0, 99) < 19);
				@(posedge clk);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		int pick;
		int chan;
		logic [1:0] sel;
		logic [1:0] acc;
		logic [2:0] mode;
		logic [7:0] high_byte;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, then the first channel 0 wrap with a full period.
		read_port(PORT_CONTROL);
		read_port(2'd0);
		read_port(2'd0);
		run_ticks(8'd0);
		run_ticks(8'd255);
		acknowledge();
		acknowledge();
		// Reload of one in the terminal count mode floods and saturates the interrupt count.
		write_port(PORT_CONTROL, control_word(2'd0, ACC_BOTH, MODE_TERMINAL, 1'b0));
		write_port(2'd0, 8'hFF);
		write_port(2'd0, 8'h00);
		write_port(2'd0, 8'h01);
		write_port(2'd0, 8'h00);
		run_ticks(8'd255);
		run_ticks(8'd255);
		acknowledge();
		// Channel 2 square wave with a short reload, then rate mode through select 3.
		write_port(PORT_CONTROL, control_word(2'd2, ACC_BOTH, MODE_SQUARE, 1'b0));
		write_port(2'd2, 8'h28);
		write_port(2'd2, 8'h00);
		run_ticks(8'd200);
		write_port(PORT_CONTROL, control_word(2'd3, ACC_BOTH, MODE_RATE, 1'b0));
		write_port(2'd2, 8'hFF);
		write_port(2'd2, 8'hFF);
		run_ticks(8'd255);
		// Count latch and the single byte access modes.
		write_port(PORT_CONTROL, control_word(2'd2, ACC_LATCH, MODE_TERMINAL, 1'b0));
		read_port(2'd2);
		read_port(2'd2);
		write_port(PORT_CONTROL, control_word(2'd1, ACC_LOW, MODE_TERMINAL, 1'b1));
		read_port(2'd1);
		write_port(PORT_CONTROL, control_word(2'd1, ACC_HIGH, MODE_TERMINAL, 1'b0));
		write_port(2'd1, 8'hAA);
		read_port(2'd1);
		read_port(PORT_CONTROL);

		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			chan = $urandom_range(0, 2);
			sel = (chan == 2 && $urandom_range(0, 1) == 1) ? 2'd3 : 2'(chan);
			if ($urandom_range(0, 3) == 0)
				mode = 3'($urandom);
			else
				mode = ($urandom_range(0, 1) == 1) ? MODE_RATE : MODE_SQUARE;
			if (pick < 20) begin
				acc = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : ACC_BOTH;
				// Mostly reloads below 256, so wraps and the ultrasonic flag come often.
				high_byte = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
				write_port(PORT_CONTROL, control_word(sel, acc, mode, 1'($urandom)));
				if (acc != ACC_HIGH)
					write_port(2'(chan), 8'($urandom));
				if (acc != ACC_LOW)
					write_port(2'(chan), high_byte);
			end else if (pick < 30) begin
				write_port(PORT_CONTROL, control_word(sel, ACC_LATCH, mode, 1'($urandom)));
				read_port(2'(chan));
				read_port(2'(chan));
			end else if (pick < 60) begin
				run_ticks(8'($urandom));
			end else if (pick < 72) begin
				read_port(2'($urandom));
			end else if (pick < 84) begin
				acknowledge();
			end else begin
				offer(itt_cmd_t'(20'($urandom)));
			end
		end

		cmd_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/itt_pkg.sv
sv/interval_timer_three_channel.sv
sv/itt_checker.sv
tb/timer_result_checker.sv
tb/tb_interval_timer_three_channel.sv
